// ----- design/sgr_pkg.sv -----
// Package for the SGR attribute decoder: step and color-kind codes,
// SGR code constants and the decoder state struct. No dependencies.
`default_nettype none

package sgr_pkg;

    // Where an extended color (38/48) sequence stands
    typedef enum logic [2:0] {
        STEP_NONE  = 3'd0,
        STEP_TYPE  = 3'd1,
        STEP_INDEX = 3'd2,
        STEP_RED   = 3'd3,
        STEP_GREEN = 3'd4,
        STEP_BLUE  = 3'd5
    } step_t;

    // Color kinds
    localparam logic [1:0] KIND_DEFAULT = 2'd0;
    localparam logic [1:0] KIND_PALETTE = 2'd1;
    localparam logic [1:0] KIND_RGB     = 2'd2;

    // SGR codes
    localparam logic [15:0] CODE_RESET       = 16'd0;
    localparam logic [15:0] CODE_INVERSE     = 16'd7;
    localparam logic [15:0] CODE_NO_INVERSE  = 16'd27;
    localparam logic [15:0] CODE_FG_FIRST    = 16'd30;
    localparam logic [15:0] CODE_FG_LAST     = 16'd37;
    localparam logic [15:0] CODE_FG_EXT      = 16'd38;
    localparam logic [15:0] CODE_FG_DEFAULT  = 16'd39;
    localparam logic [15:0] CODE_BG_FIRST    = 16'd40;
    localparam logic [15:0] CODE_BG_LAST     = 16'd47;
    localparam logic [15:0] CODE_BG_EXT      = 16'd48;
    localparam logic [15:0] CODE_BG_DEFAULT  = 16'd49;
    localparam logic [15:0] CODE_FGB_FIRST   = 16'd90;
    localparam logic [15:0] CODE_FGB_LAST    = 16'd97;
    localparam logic [15:0] CODE_BGB_FIRST   = 16'd100;
    localparam logic [15:0] CODE_BGB_LAST    = 16'd107;

    // Extended color type sub-parameters
    localparam logic [7:0] EXT_TYPE_INDEX = 8'd5;
    localparam logic [7:0] EXT_TYPE_RGB   = 8'd2;

    // Bright palette entries start here
    localparam logic [3:0] BRIGHT_BASE = 4'd8;

    typedef struct packed {
        step_t       step;
        logic        is_bg;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [1:0]  fg_mode;
        logic [23:0] fg_value;
        logic [1:0]  bg_mode;
        logic [23:0] bg_value;
        logic        inverse;
    } sgr_state_t;

endpackage

`default_nettype wire

// ----- design/sgr_decode.sv -----
// Next-state logic of the SGR attribute decoder: one parameter word in,
// updated color and pending state out. Depends on sgr_pkg.
`default_nettype none

module sgr_decode (
    input  wire sgr_pkg::sgr_state_t cur,
    input  wire logic [15:0]         param,
    input  wire logic                seq_start,
    input  wire logic                seq_empty,
    output sgr_pkg::sgr_state_t      nxt
);

    logic [7:0]     low;
    logic [2:0]     fg_off;
    logic [2:0]     bg_off;
    logic [2:0]     fgb_off;
    logic [2:0]     bgb_off;
    sgr_pkg::step_t step_eff;
    logic [23:0]    rgb;

    assign low      = param[7:0];
    assign fg_off   = 3'(param - sgr_pkg::CODE_FG_FIRST);
    assign bg_off   = 3'(param - sgr_pkg::CODE_BG_FIRST);
    assign fgb_off  = 3'(param - sgr_pkg::CODE_FGB_FIRST);
    assign bgb_off  = 3'(param - sgr_pkg::CODE_BGB_FIRST);
    assign step_eff = seq_start ? sgr_pkg::STEP_NONE : cur.step;
    assign rgb      = {cur.red, cur.green, low};

    always_comb
    begin
        nxt = cur;
        if (seq_empty)
        begin
            nxt.step     = sgr_pkg::STEP_NONE;
            nxt.fg_mode  = sgr_pkg::KIND_DEFAULT;
            nxt.fg_value = 24'd0;
            nxt.bg_mode  = sgr_pkg::KIND_DEFAULT;
            nxt.bg_value = 24'd0;
        end
        else
        begin
            case (step_eff)
                sgr_pkg::STEP_TYPE:
                begin
                    if (low == sgr_pkg::EXT_TYPE_INDEX)
                        nxt.step = sgr_pkg::STEP_INDEX;
                    else if (low == sgr_pkg::EXT_TYPE_RGB)
                        nxt.step = sgr_pkg::STEP_RED;
                    else
                        nxt.step = sgr_pkg::STEP_NONE;
                end
                sgr_pkg::STEP_INDEX:
                begin
                    nxt.step = sgr_pkg::STEP_NONE;
                    if (cur.is_bg)
                    begin
                        nxt.bg_mode  = sgr_pkg::KIND_PALETTE;
                        nxt.bg_value = {16'd0, low};
                    end
                    else
                    begin
                        nxt.fg_mode  = sgr_pkg::KIND_PALETTE;
                        nxt.fg_value = {16'd0, low};
                    end
                end
                sgr_pkg::STEP_RED:
                begin
                    nxt.red  = low;
                    nxt.step = sgr_pkg::STEP_GREEN;
                end
                sgr_pkg::STEP_GREEN:
                begin
                    nxt.green = low;
                    nxt.step  = sgr_pkg::STEP_BLUE;
                end
                sgr_pkg::STEP_BLUE:
                begin
                    nxt.step = sgr_pkg::STEP_NONE;
                    if (cur.is_bg)
                    begin
                        nxt.bg_mode  = sgr_pkg::KIND_RGB;
                        nxt.bg_value = rgb;
                    end
                    else
                    begin
                        nxt.fg_mode  = sgr_pkg::KIND_RGB;
                        nxt.fg_value = rgb;
                    end
                end
                default:
                begin
                    // plain code
                    nxt.step = sgr_pkg::STEP_NONE;
                    if (param == sgr_pkg::CODE_RESET)
                    begin
                        nxt.fg_mode  = sgr_pkg::KIND_DEFAULT;
                        nxt.fg_value = 24'd0;
                        nxt.bg_mode  = sgr_pkg::KIND_DEFAULT;
                        nxt.bg_value = 24'd0;
                    end
                    else if (param == sgr_pkg::CODE_INVERSE)
                        nxt.inverse = 1'b1;
                    else if (param == sgr_pkg::CODE_NO_INVERSE)
                        nxt.inverse = 1'b0;
                    else if (param == sgr_pkg::CODE_FG_EXT
                             || param == sgr_pkg::CODE_BG_EXT)
                    begin
                        nxt.is_bg = (param == sgr_pkg::CODE_BG_EXT);
                        nxt.step  = sgr_pkg::STEP_TYPE;
                    end
                    else if (param >= sgr_pkg::CODE_FG_FIRST
                             && param <= sgr_pkg::CODE_FG_LAST)
                    begin
                        nxt.fg_mode  = sgr_pkg::KIND_PALETTE;
                        nxt.fg_value = {21'd0, fg_off};
                    end
                    else if (param == sgr_pkg::CODE_FG_DEFAULT)
                    begin
                        nxt.fg_mode  = sgr_pkg::KIND_DEFAULT;
                        nxt.fg_value = 24'd0;
                    end
                    else if (param >= sgr_pkg::CODE_BG_FIRST
                             && param <= sgr_pkg::CODE_BG_LAST)
                    begin
                        nxt.bg_mode  = sgr_pkg::KIND_PALETTE;
                        nxt.bg_value = {21'd0, bg_off};
                    end
                    else if (param == sgr_pkg::CODE_BG_DEFAULT)
                    begin
                        nxt.bg_mode  = sgr_pkg::KIND_DEFAULT;
                        nxt.bg_value = 24'd0;
                    end
                    else if (param >= sgr_pkg::CODE_FGB_FIRST
                             && param <= sgr_pkg::CODE_FGB_LAST)
                    begin
                        nxt.fg_mode  = sgr_pkg::KIND_PALETTE;
                        nxt.fg_value = {20'd0, sgr_pkg::BRIGHT_BASE | {1'b0, fgb_off}};
                    end
                    else if (param >= sgr_pkg::CODE_BGB_FIRST
                             && param <= sgr_pkg::CODE_BGB_LAST)
                    begin
                        nxt.bg_mode  = sgr_pkg::KIND_PALETTE;
                        nxt.bg_value = {20'd0, sgr_pkg::BRIGHT_BASE | {1'b0, bgb_off}};
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/sgr_attribute_decoder_unit.sv -----
// Top level of the SGR attribute decoder: input word register, decoder
// state, result register. Depends on sgr_pkg and sgr_decode.
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: param; s_tuser: seq_start, seq_empty
// m_        out  m_tvalid/m_tready  m_tdata: fg_mode, fg_value, bg_mode, bg_value,
//                                            inverse_on
//
// Each word goes from input to output through the input register, then is
// decoded into state and result register; one word is taken every cycle
// while the output is not stalled. The state update (pending step, held
// red/green, colors) done as each word moves on sets that rate. Reset (rst_n
// low, asynchronous) clears the state to default colors with nothing pending
// and empties both registers. A stalled output holds its word; the input register
// keeps taking words as long as the result register can move on in the same cycle.

module sgr_attribute_decoder_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] param
    input  wire logic [1:0]  s_tuser,   // [0] seq_start, [1] seq_empty
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata    // [1:0] fg_mode, [25:2] fg_value,
                                        // [27:26] bg_mode, [51:28] bg_value,
                                        // [52] inverse_on, [55:53] zero
);

    logic                in_valid_reg;
    logic [15:0]         in_param_reg;
    logic                in_start_reg;
    logic                in_empty_reg;
    logic                out_valid_reg;
    logic [52:0]         out_data_reg;
    sgr_pkg::sgr_state_t state_reg;
    sgr_pkg::sgr_state_t state_next;
    logic                advance;
    logic                s_accept;

    // Input word moves into the decoder when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_data_reg};

    sgr_decode u_decode (
        .cur       (state_reg),
        .param     (in_param_reg),
        .seq_start (in_start_reg),
        .seq_empty (in_empty_reg),
        .nxt       (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_accept)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_param_reg <= s_tdata;
            in_start_reg <= s_tuser[0];
            in_empty_reg <= s_tuser[1];
        end
    end

    // Decoder state: updated once per word, together with the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.step     <= sgr_pkg::STEP_NONE;
            state_reg.is_bg    <= 1'b0;
            state_reg.red      <= 8'd0;
            state_reg.green    <= 8'd0;
            state_reg.fg_mode  <= sgr_pkg::KIND_DEFAULT;
            state_reg.fg_value <= 24'd0;
            state_reg.bg_mode  <= sgr_pkg::KIND_DEFAULT;
            state_reg.bg_value <= 24'd0;
            state_reg.inverse  <= 1'b0;
        end
        else if (advance)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= {state_next.inverse, state_next.bg_value, state_next.bg_mode,
                             state_next.fg_value, state_next.fg_mode};
    end

    // An empty sequence leaves both colors default in the word it produces
    a_empty_resets: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_empty_reg |=> m_tvalid && m_tdata[1:0] == sgr_pkg::KIND_DEFAULT
            && m_tdata[27:26] == sgr_pkg::KIND_DEFAULT && m_tdata[25:2] == 24'd0
            && m_tdata[51:28] == 24'd0)
        else $error("empty sequence did not reset colors");

    // State moves only with a word going into the result register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("decoder state changed without a word");

    // A default foreground color always carries value zero
    a_default_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.fg_mode == sgr_pkg::KIND_DEFAULT |-> state_reg.fg_value == 24'd0)
        else $error("default foreground with nonzero value");

endmodule

`default_nettype wire
